// File: rtl/cpio_newc_archive_validator_macros.svh
// Assertion helpers included by the validator top module.
`ifndef CPIO_NEWC_ARCHIVE_VALIDATOR_MACROS_SVH
`define CPIO_NEWC_ARCHIVE_VALIDATOR_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define CPNV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define CPNV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/cpnv_pkg.sv
package cpnv_pkg;

  typedef struct packed {
    logic [7:0] archive_byte;
    logic       is_last;
  } in_t;

  typedef struct packed {
    logic        record_kind;
    logic [1:0]  status;
    logic [4:0]  entry_index;
    logic [31:0] data_offset;
    logic [31:0] data_size;
    logic [31:0] entry_mode;
    logic [5:0]  entry_count;
  } out_t;

  typedef struct packed {
    logic done;
    logic dup;
  } dup_res_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [8:0] {
    PH_MAGIC  = 9'b000000001,
    PH_FIELDS = 9'b000000010,
    PH_NAME   = 9'b000000100,
    PH_NPAD   = 9'b000001000,
    PH_DATA   = 9'b000010000,
    PH_DPAD   = 9'b000100000,
    PH_TAILZ  = 9'b001000000,
    PH_HALT   = 9'b010000000,
    PH_DUP    = 9'b100000000
  } phase_e;

  localparam logic REC_ENTRY  = 1'b0;
  localparam logic REC_STATUS = 1'b1;

  localparam int unsigned OFF_W        = 33;
  localparam int unsigned NAME_W       = 9;
  localparam int unsigned POS_W        = 9;
  localparam int unsigned FIELD_DIGITS = 8;
  localparam int unsigned NUM_FIELDS   = 13;
  localparam int unsigned MAGIC_LEN    = 6;
  localparam int unsigned TRAILER_LEN  = 10;
  localparam int unsigned TRAILER_NSZ  = 11;
  localparam int unsigned F_MODE       = 1;
  localparam int unsigned F_NLINK      = 4;
  localparam int unsigned F_FSIZE      = 6;
  localparam int unsigned F_NSIZE      = 11;
  localparam int unsigned F_CHECK      = 12;

  localparam logic [31:0] MODE_TYPE_MASK = 32'o170000;
  localparam logic [31:0] MODE_REG       = 32'o100000;
  localparam logic [31:0] MODE_DIR       = 32'o040000;
  localparam logic [31:0] MAX_BYTES_RST  = 32'd16777216;

  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd5:    c = 8'h31;
      3'd1,
      3'd3:    c = 8'h37;
      default: c = 8'h30;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] trailer_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h54;
      4'd1:    c = 8'h52;
      4'd2:    c = 8'h41;
      4'd3:    c = 8'h49;
      4'd4:    c = 8'h4C;
      4'd5:    c = 8'h45;
      4'd6:    c = 8'h52;
      default: c = 8'h21;
    endcase
    return c;
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
           (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [3:0] v;
    if (b <= 8'h39) begin
      v = b[3:0];
    end else begin
      v = 4'(b[2:0] + 3'd1) + 4'd8;
    end
    return v;
  endfunction

  function automatic logic name_char_ok(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h30 && b <= 8'h39) || b == 8'h2E || b == 8'h5F || b == 8'h2D;
  endfunction

endpackage

// File: rtl/cpnv_ram.sv
module cpnv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/cpnv_dupchk.sv
module cpnv_dupchk #(
  parameter int unsigned MAX_ENTRIES    = 32,
  parameter int unsigned NAME_BYTES_MAX = 256
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start_i,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0]         count_i,
  input  logic [cpnv_pkg::NAME_W-1:0]              nsize_i,
  input  logic [7:0]                               cur_byte_i,
  input  logic [7:0]                               st_byte_i,
  output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] slot_o,
  output logic [$clog2(NAME_BYTES_MAX)-1:0]        idx_o,
  output cpnv_pkg::dup_res_t                       res_o
);

  localparam int unsigned SW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned JW = $clog2(NAME_BYTES_MAX);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  logic          busy_q, busy_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [JW-1:0] idx_q, idx_d;
  logic          rd_q, rd_d;
  logic          lastb_q, lastb_d;
  logic          fin_q, fin_d;
  logic          mism_q, mism_d;
  logic          done_q, done_d;
  logic          dup_q, dup_d;
  logic          issue_last;
  logic          issue_final;
  logic          mism_n;

  assign issue_last  = cpnv_pkg::NAME_W'(idx_q) == nsize_i - cpnv_pkg::NAME_W'(1);
  assign issue_final = issue_last && (CW'(slot_q) + CW'(1) == count_i);
  assign mism_n      = mism_q | (cur_byte_i != st_byte_i);

  always_comb begin
    busy_d  = busy_q;
    slot_d  = slot_q;
    idx_d   = idx_q;
    rd_d    = 1'b0;
    lastb_d = lastb_q;
    fin_d   = fin_q;
    mism_d  = mism_q;
    done_d  = done_q;
    dup_d   = dup_q;
    if (start_i) begin
      busy_d = count_i != '0;
      done_d = count_i == '0;
      dup_d  = 1'b0;
      slot_d = '0;
      idx_d  = '0;
      mism_d = 1'b0;
    end else begin
      if (busy_q) begin
        rd_d    = 1'b1;
        lastb_d = issue_last;
        fin_d   = issue_final;
        if (issue_last) begin
          idx_d = '0;
          if (issue_final) begin
            busy_d = 1'b0;
          end else begin
            slot_d = slot_q + SW'(1);
          end
        end else begin
          idx_d = idx_q + JW'(1);
        end
      end
      if (rd_q) begin
        if (lastb_q) begin
          if (!mism_n) begin
            dup_d = 1'b1;
          end
          mism_d = 1'b0;
          if (fin_q) begin
            done_d = 1'b1;
          end
        end else begin
          mism_d = mism_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      slot_q  <= '0;
      idx_q   <= '0;
      rd_q    <= 1'b0;
      lastb_q <= 1'b0;
      fin_q   <= 1'b0;
      mism_q  <= 1'b0;
      done_q  <= 1'b0;
      dup_q   <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      slot_q  <= slot_d;
      idx_q   <= idx_d;
      rd_q    <= rd_d;
      lastb_q <= lastb_d;
      fin_q   <= fin_d;
      mism_q  <= mism_d;
      done_q  <= done_d;
      dup_q   <= dup_d;
    end
  end

  assign slot_o   = slot_q;
  assign idx_o    = idx_q;
  assign res_o.done = done_q;
  assign res_o.dup  = dup_q;

endmodule

// File: rtl/cpio_newc_archive_validator.sv
// cpio newc archive validator.
// Input channel: one archive byte per request with a last flag (in_valid_i /
// in_stall_o). Output channel: entry records and one final status per archive
// (out_valid_o / out_stall_i), through a single output register.
// The final status is registered and visible in the cycle after the last byte is
// taken, an entry record once the name compare below has finished.
// At the end of each non-trailer entry that passes its checks and fits in the table
// the block checks the name against all stored names: it reads the name memory and
// the current-name buffer one byte a cycle, holding in_stall_o until the compare
// finishes, as the name memory has a single read port.
// Entry records are valid only if the final status of the archive is OK.
// The final status comes with the last byte; the block then starts afresh on
// the next archive, keeping max_archive_bytes.
// Reset clears all parse state and sets max_archive_bytes to 16 MiB; the name
// memories need no clearing, only slots below the entry count are read.
// When the receiver stalls, a waiting result holds and input is stalled until
// the output register frees.
module cpio_newc_archive_validator #(
  parameter int unsigned MAX_ENTRIES    = 32,
  parameter int unsigned NAME_BYTES_MAX = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  cpnv_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output cpnv_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [31:0]    cfg_wdata_i
);

  localparam int unsigned SW       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned JW       = $clog2(NAME_BYTES_MAX);
  localparam int unsigned CW       = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned NS_DEPTH = (2 ** SW) * (2 ** JW);
  localparam int unsigned POS_W    = cpnv_pkg::POS_W;
  localparam int unsigned OFF_W    = cpnv_pkg::OFF_W;
  localparam int unsigned FD       = cpnv_pkg::FIELD_DIGITS;
  localparam logic [POS_W-1:0] POS_MODE  = POS_W'((cpnv_pkg::F_MODE + 1) * FD);
  localparam logic [POS_W-1:0] POS_NLINK = POS_W'((cpnv_pkg::F_NLINK + 1) * FD);
  localparam logic [POS_W-1:0] POS_FSIZE = POS_W'((cpnv_pkg::F_FSIZE + 1) * FD);
  localparam logic [POS_W-1:0] POS_NSIZE = POS_W'((cpnv_pkg::F_NSIZE + 1) * FD);
  localparam logic [POS_W-1:0] POS_CHECK = POS_W'((cpnv_pkg::F_CHECK + 1) * FD);
  localparam logic [POS_W-1:0] POS_HDR   = POS_W'(cpnv_pkg::NUM_FIELDS * FD);
  localparam logic [OFF_W-1:0] OFF_MAX   = {OFF_W{1'b1}};

  cpnv_pkg::phase_e phase_q, phase_d;
  logic [OFF_W-1:0] off_q, off_d;
  logic [31:0]      acc_q, acc_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [31:0]      mode_q, mode_d;
  logic [31:0]      fsize_q, fsize_d;
  logic [cpnv_pkg::NAME_W-1:0] nsize_q, nsize_d;
  logic             nbad_q, nbad_d;
  logic             nlink_q, nlink_d;
  logic             chk_q, chk_d;
  logic [31:0]      rem_q, rem_d;
  logic [31:0]      dstart_q, dstart_d;
  logic [1:0]       clen_q, clen_d;
  logic             dots_q, dots_d;
  logic             pbad_q, pbad_d;
  logic             trl_q, trl_d;
  logic [CW-1:0]    count_q, count_d;
  logic [1:0]       status_q, status_d;
  logic [31:0]      max_q;
  logic             out_valid_q, out_valid_d;
  cpnv_pkg::out_t   out_data_q, out_data_d;

  logic             in_acc;
  logic             out_free;
  logic [OFF_W-1:0] off_inc;
  logic [7:0]       b;
  logic             adv;
  logic             nwe;
  logic             dup_start;
  logic             boundary;
  logic [31:0]      mtype;
  logic             ent_bad;
  logic [1:0]       fin_st;
  logic [1:0]       pad_n;

  logic [SW-1:0]      cmp_slot;
  logic [JW-1:0]      cmp_idx;
  logic [7:0]         cur_byte;
  logic [7:0]         st_byte;
  cpnv_pkg::dup_res_t dres;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (phase_q == cpnv_pkg::PH_DUP) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign b          = in_data_i.archive_byte;
  assign off_inc    = (off_q == OFF_MAX) ? off_q : off_q + OFF_W'(1);
  assign pad_n      = 2'(~off_inc[1:0] + 2'd1);
  assign mtype      = mode_q & cpnv_pkg::MODE_TYPE_MASK;

  always_comb begin
    phase_d     = phase_q;
    off_d       = off_q;
    acc_d       = acc_q;
    pos_d       = pos_q;
    mode_d      = mode_q;
    fsize_d     = fsize_q;
    nsize_d     = nsize_q;
    nbad_d      = nbad_q;
    nlink_d     = nlink_q;
    chk_d       = chk_q;
    rem_d       = rem_q;
    dstart_d    = dstart_q;
    clen_d      = clen_q;
    dots_d      = dots_q;
    pbad_d      = pbad_q;
    trl_d       = trl_q;
    count_d     = count_q;
    status_d    = status_q;
    out_valid_d = out_free ? 1'b0 : out_valid_q;
    out_data_d  = out_data_q;
    adv         = 1'b0;
    nwe         = 1'b0;
    dup_start   = 1'b0;
    boundary    = 1'b0;
    ent_bad     = 1'b0;
    fin_st      = cpnv_pkg::ST_INVALID;

    if (in_acc) begin
      off_d = off_inc;
      unique case (phase_q)
        cpnv_pkg::PH_MAGIC: begin
          if (b != cpnv_pkg::magic_char(pos_q[2:0])) begin
            status_d = cpnv_pkg::ST_INVALID;
            phase_d  = cpnv_pkg::PH_HALT;
          end else begin
            pos_d = pos_q + POS_W'(1);
            if (pos_d == POS_W'(cpnv_pkg::MAGIC_LEN)) begin
              phase_d = cpnv_pkg::PH_FIELDS;
              pos_d   = '0;
              acc_d   = '0;
            end
          end
        end
        cpnv_pkg::PH_FIELDS: begin
          if (!cpnv_pkg::is_hex(b)) begin
            status_d = cpnv_pkg::ST_INVALID;
            phase_d  = cpnv_pkg::PH_HALT;
          end else begin
            acc_d = {acc_q[27:0], cpnv_pkg::hex_val(b)};
            pos_d = pos_q + POS_W'(1);
            if (pos_d[2:0] == 3'd0) begin
              if (pos_d == POS_MODE) begin
                mode_d = acc_d;
              end else if (pos_d == POS_NLINK) begin
                nlink_d = acc_d == 32'd1;
              end else if (pos_d == POS_FSIZE) begin
                fsize_d = acc_d;
              end else if (pos_d == POS_NSIZE) begin
                nsize_d = acc_d[cpnv_pkg::NAME_W-1:0];
                nbad_d  = (acc_d == '0) || (acc_d > 32'(NAME_BYTES_MAX));
              end else if (pos_d == POS_CHECK) begin
                chk_d = acc_d != '0;
              end
              acc_d = '0;
            end
            if (pos_d == POS_HDR) begin
              if (nbad_d || chk_d) begin
                status_d = cpnv_pkg::ST_INVALID;
                phase_d  = cpnv_pkg::PH_HALT;
              end else begin
                phase_d = cpnv_pkg::PH_NAME;
                pos_d   = '0;
                clen_d  = '0;
                dots_d  = 1'b1;
                pbad_d  = 1'b0;
                trl_d   = 1'b1;
              end
            end
          end
        end
        cpnv_pkg::PH_NAME: begin
          nwe   = 1'b1;
          pos_d = pos_q + POS_W'(1);
          if (pos_q < POS_W'(cpnv_pkg::TRAILER_LEN) &&
              b != cpnv_pkg::trailer_char(pos_q[3:0])) begin
            trl_d = 1'b0;
          end
          boundary = (pos_d >= POS_W'(nsize_q)) || (b == 8'h2F);
          if (boundary) begin
            if (clen_q == 2'd0 || (dots_q && (clen_q == 2'd1 || clen_q == 2'd2))) begin
              pbad_d = 1'b1;
            end
            clen_d = '0;
            dots_d = 1'b1;
          end else begin
            if (!cpnv_pkg::name_char_ok(b)) begin
              pbad_d = 1'b1;
            end
            if (clen_q != 2'd3) begin
              clen_d = clen_q + 2'd1;
            end
            dots_d = dots_q && (b == 8'h2E);
          end
          if (pos_d >= POS_W'(nsize_q)) begin
            if (b != 8'h00) begin
              status_d = cpnv_pkg::ST_INVALID;
              phase_d  = cpnv_pkg::PH_HALT;
            end else begin
              rem_d   = 32'(pad_n);
              phase_d = cpnv_pkg::PH_NPAD;
              adv     = 1'b1;
            end
          end
        end
        cpnv_pkg::PH_NPAD,
        cpnv_pkg::PH_DATA,
        cpnv_pkg::PH_DPAD: begin
          if (rem_q != '0) begin
            rem_d = rem_q - 32'd1;
          end
          adv = 1'b1;
        end
        cpnv_pkg::PH_TAILZ: begin
          if (b != 8'h00) begin
            status_d = cpnv_pkg::ST_INVALID;
            phase_d  = cpnv_pkg::PH_HALT;
          end
        end
        cpnv_pkg::PH_HALT,
        cpnv_pkg::PH_DUP: begin
        end
      endcase

      if (adv) begin
        if (phase_d == cpnv_pkg::PH_NPAD && rem_d == '0) begin
          dstart_d = off_inc[31:0];
          rem_d    = fsize_q;
          phase_d  = cpnv_pkg::PH_DATA;
        end
        if (phase_d == cpnv_pkg::PH_DATA && rem_d == '0) begin
          rem_d   = 32'(pad_n);
          phase_d = cpnv_pkg::PH_DPAD;
        end
        if (phase_d == cpnv_pkg::PH_DPAD && rem_d == '0) begin
          if (nsize_q == cpnv_pkg::NAME_W'(cpnv_pkg::TRAILER_NSZ) && trl_d) begin
            if (fsize_q != '0 || mode_q != '0) begin
              status_d = cpnv_pkg::ST_INVALID;
              phase_d  = cpnv_pkg::PH_HALT;
            end else begin
              phase_d = cpnv_pkg::PH_TAILZ;
            end
          end else begin
            ent_bad = pbad_d ||
                      (mtype != cpnv_pkg::MODE_REG && mtype != cpnv_pkg::MODE_DIR) ||
                      (mtype == cpnv_pkg::MODE_REG && !nlink_q) ||
                      (mtype == cpnv_pkg::MODE_DIR && fsize_q != '0);
            if (ent_bad) begin
              status_d = cpnv_pkg::ST_INVALID;
              phase_d  = cpnv_pkg::PH_HALT;
            end else if (count_q >= CW'(MAX_ENTRIES)) begin
              status_d = cpnv_pkg::ST_FULL;
              phase_d  = cpnv_pkg::PH_HALT;
            end else begin
              phase_d   = cpnv_pkg::PH_DUP;
              dup_start = !in_data_i.is_last;
            end
          end
        end
      end

      if (in_data_i.is_last) begin
        priority if (off_inc > {1'b0, max_q}) begin
          fin_st = cpnv_pkg::ST_INVALID;
        end else if (status_d != cpnv_pkg::ST_OK) begin
          fin_st = status_d;
        end else if (phase_d == cpnv_pkg::PH_TAILZ) begin
          fin_st = cpnv_pkg::ST_OK;
        end else begin
          fin_st = cpnv_pkg::ST_INVALID;
        end
        out_valid_d             = 1'b1;
        out_data_d              = '0;
        out_data_d.record_kind  = cpnv_pkg::REC_STATUS;
        out_data_d.status       = fin_st;
        out_data_d.entry_count  = (fin_st == cpnv_pkg::ST_OK) ? 6'(count_q) : 6'd0;
        phase_d  = cpnv_pkg::PH_MAGIC;
        off_d    = '0;
        acc_d    = '0;
        pos_d    = '0;
        mode_d   = '0;
        fsize_d  = '0;
        nsize_d  = '0;
        nbad_d   = 1'b0;
        nlink_d  = 1'b0;
        chk_d    = 1'b0;
        rem_d    = '0;
        dstart_d = '0;
        clen_d   = '0;
        dots_d   = 1'b0;
        pbad_d   = 1'b0;
        trl_d    = 1'b0;
        count_d  = '0;
        status_d = cpnv_pkg::ST_OK;
      end
    end else if (phase_q == cpnv_pkg::PH_DUP && dres.done && out_free) begin
      if (dres.dup) begin
        status_d = cpnv_pkg::ST_INVALID;
        phase_d  = cpnv_pkg::PH_HALT;
      end else begin
        out_valid_d            = 1'b1;
        out_data_d             = '0;
        out_data_d.record_kind = cpnv_pkg::REC_ENTRY;
        out_data_d.status      = cpnv_pkg::ST_OK;
        out_data_d.entry_index = 5'(count_q);
        out_data_d.data_offset = dstart_q;
        out_data_d.data_size   = fsize_q;
        out_data_d.entry_mode  = mode_q;
        count_d = count_q + CW'(1);
        phase_d = cpnv_pkg::PH_MAGIC;
        pos_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= cpnv_pkg::PH_MAGIC;
      off_q       <= '0;
      acc_q       <= '0;
      pos_q       <= '0;
      mode_q      <= '0;
      fsize_q     <= '0;
      nsize_q     <= '0;
      nbad_q      <= 1'b0;
      nlink_q     <= 1'b0;
      chk_q       <= 1'b0;
      rem_q       <= '0;
      dstart_q    <= '0;
      clen_q      <= '0;
      dots_q      <= 1'b0;
      pbad_q      <= 1'b0;
      trl_q       <= 1'b0;
      count_q     <= '0;
      status_q    <= cpnv_pkg::ST_OK;
      max_q       <= cpnv_pkg::MAX_BYTES_RST;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      off_q       <= off_d;
      acc_q       <= acc_d;
      pos_q       <= pos_d;
      mode_q      <= mode_d;
      fsize_q     <= fsize_d;
      nsize_q     <= nsize_d;
      nbad_q      <= nbad_d;
      nlink_q     <= nlink_d;
      chk_q       <= chk_d;
      rem_q       <= rem_d;
      dstart_q    <= dstart_d;
      clen_q      <= clen_d;
      dots_q      <= dots_d;
      pbad_q      <= pbad_d;
      trl_q       <= trl_d;
      count_q     <= count_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  cpnv_ram #(
    .WIDTH (8),
    .DEPTH (2 ** JW)
  ) u_cur_name (
    .clk_i   (clk_i),
    .we_i    (nwe),
    .waddr_i (pos_q[JW-1:0]),
    .wdata_i (b),
    .raddr_i (cmp_idx),
    .rdata_o (cur_byte)
  );

  cpnv_ram #(
    .WIDTH (8),
    .DEPTH (NS_DEPTH)
  ) u_name_store (
    .clk_i   (clk_i),
    .we_i    (nwe && (count_q < CW'(MAX_ENTRIES))),
    .waddr_i ({count_q[SW-1:0], pos_q[JW-1:0]}),
    .wdata_i (b),
    .raddr_i ({cmp_slot, cmp_idx}),
    .rdata_o (st_byte)
  );

  cpnv_dupchk #(
    .MAX_ENTRIES    (MAX_ENTRIES),
    .NAME_BYTES_MAX (NAME_BYTES_MAX)
  ) u_dupchk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dup_start),
    .count_i    (count_q),
    .nsize_i    (nsize_q),
    .cur_byte_i (cur_byte),
    .st_byte_i  (st_byte),
    .slot_o     (cmp_slot),
    .idx_o      (cmp_idx),
    .res_o      (dres)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`include "cpio_newc_archive_validator_macros.svh"

  `CPNV_ASSERT_NOW(a_dup_stalls_input, phase_q == cpnv_pkg::PH_DUP, in_stall_o, "input taken during name compare")
  `CPNV_ASSERT_NOW(a_count_bounded, 1'b1, count_q <= CW'(MAX_ENTRIES), "entry count above table size")
  `CPNV_ASSERT_NOW(a_entry_rec_ok, out_valid_o && out_data_o.record_kind == cpnv_pkg::REC_ENTRY, out_data_o.status == cpnv_pkg::ST_OK && out_data_o.entry_count == 6'd0, "entry record with status")
  `CPNV_ASSERT_NEXT(a_last_gives_status, in_acc && in_data_i.is_last, out_valid_o && out_data_o.record_kind == cpnv_pkg::REC_STATUS, "last byte without status record")

endmodule

// File: dv/tb_cpio_newc_archive_validator.sv
`timescale 1ns / 1ps

module tb_cpio_newc_archive_validator;
  import cpnv_pkg::*;

  localparam int unsigned ENTRIES_MAX = 32;
  localparam int unsigned NAME_MAX    = 256;
  localparam longint unsigned OFF_CAP = 64'h1_FFFF_FFFF;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_t        out_data_o;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  cpio_newc_archive_validator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // predicted validator state
  logic [31:0]     size_limit;
  phase_e          phase;
  longint unsigned consumed;
  logic [31:0]     acc;
  int unsigned     digit_pos;
  logic [31:0]     hdr_mode;
  logic [31:0]     hdr_fsize;
  logic [31:0]     hdr_nsize;
  bit              nlink_one;
  bit              check_set;
  logic [31:0]     remaining;
  logic [31:0]     data_base;
  logic [7:0]      cur_name [NAME_MAX];
  logic [7:0]      kept_names [ENTRIES_MAX][NAME_MAX];
  int unsigned     kept_len [ENTRIES_MAX];
  int unsigned     kept_count;
  status_e         sticky_status;

  out_t        pending_records [$];
  int unsigned errors;
  logic [7:0]  arc [$];
  bit          no_idle;
  bit          rx_hold;
  int unsigned bytes_sent;

  function automatic void restart_parse();
    phase         = PH_MAGIC;
    consumed      = 0;
    acc           = '0;
    digit_pos     = 0;
    hdr_mode      = '0;
    hdr_fsize     = '0;
    hdr_nsize     = '0;
    nlink_one     = 1'b0;
    check_set     = 1'b0;
    remaining     = '0;
    data_base     = '0;
    kept_count    = 0;
    sticky_status = ST_OK;
  endfunction

  function automatic void halt_with(status_e s);
    sticky_status = s;
    phase         = PH_HALT;
  endfunction

  function automatic logic [31:0] pad_of(longint unsigned o);
    return (32'd4 - {30'd0, o[1:0]}) & 32'd3;
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic bit path_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == "." || c == "_" || c == "-";
  endfunction

  function automatic bit path_good(int unsigned n);
    int unsigned beg;
    int unsigned len;
    beg = 0;
    if (n < 2 || n > NAME_MAX) return 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      if (i == n - 1 || cur_name[i] == "/") begin
        len = i - beg;
        if (len == 0) return 1'b0;
        if (len == 1 && cur_name[beg] == ".") return 1'b0;
        if (len == 2 && cur_name[beg] == "." && cur_name[beg+1] == ".") return 1'b0;
        beg = i + 1;
      end else if (!path_char(cur_name[i])) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic bit close_entry();
    logic [31:0] kind;
    bit          same;
    string       tr;
    bit          is_tr;
    kind  = hdr_mode & MODE_TYPE_MASK;
    tr    = "TRAILER!!!";
    is_tr = (hdr_nsize == 11);
    for (int i = 0; i < 10; i++) if (cur_name[i] != tr[i]) is_tr = 1'b0;
    if (is_tr) begin
      if (hdr_fsize != 0 || hdr_mode != 0) begin
        halt_with(ST_INVALID);
        return 1'b0;
      end
      phase = PH_TAILZ;
      return 1'b0;
    end
    if (!path_good(hdr_nsize) || (kind != MODE_REG && kind != MODE_DIR) ||
        (kind == MODE_REG && !nlink_one) || (kind == MODE_DIR && hdr_fsize != 0)) begin
      halt_with(ST_INVALID);
      return 1'b0;
    end
    if (kept_count >= ENTRIES_MAX) begin
      halt_with(ST_FULL);
      return 1'b0;
    end
    for (int unsigned i = 0; i < kept_count; i++) begin
      same = (kept_len[i] == hdr_nsize);
      for (int unsigned j = 0; same && j < hdr_nsize; j++)
        if (kept_names[i][j] != cur_name[j]) same = 1'b0;
      if (same) begin
        halt_with(ST_INVALID);
        return 1'b0;
      end
    end
    for (int unsigned j = 0; j < hdr_nsize; j++) kept_names[kept_count][j] = cur_name[j];
    kept_len[kept_count] = hdr_nsize;
    kept_count++;
    phase     = PH_MAGIC;
    digit_pos = 0;
    return 1'b1;
  endfunction

  function automatic bit skip_empty();
    if (phase == PH_NPAD && remaining == 0) begin
      data_base = consumed[31:0];
      remaining = hdr_fsize;
      phase     = PH_DATA;
    end
    if (phase == PH_DATA && remaining == 0) begin
      remaining = pad_of(consumed);
      phase     = PH_DPAD;
    end
    if (phase == PH_DPAD && remaining == 0) return close_entry();
    return 1'b0;
  endfunction

  function automatic bit take_byte(logic [7:0] b);
    string       mg;
    int          d;
    int unsigned f;
    mg = "070701";
    case (phase)
      PH_MAGIC: begin
        if (digit_pos >= 6 || b != mg[digit_pos]) begin
          halt_with(ST_INVALID);
          return 1'b0;
        end
        digit_pos++;
        if (digit_pos == 6) begin
          phase     = PH_FIELDS;
          digit_pos = 0;
          acc       = '0;
        end
      end
      PH_FIELDS: begin
        d = hex_digit(b);
        if (d < 0) begin
          halt_with(ST_INVALID);
          return 1'b0;
        end
        acc = (acc << 4) | 32'(d);
        digit_pos++;
        if (digit_pos % 8 == 0) begin
          f = digit_pos / 8 - 1;
          if (f == F_MODE) hdr_mode = acc;
          else if (f == F_NLINK) nlink_one = (acc == 1);
          else if (f == F_FSIZE) hdr_fsize = acc;
          else if (f == F_NSIZE) hdr_nsize = acc;
          else if (f == F_CHECK) check_set = (acc != 0);
          acc = '0;
        end
        if (digit_pos == 104) begin
          if (hdr_nsize == 0 || hdr_nsize > NAME_MAX || check_set) begin
            halt_with(ST_INVALID);
            return 1'b0;
          end
          phase     = PH_NAME;
          digit_pos = 0;
        end
      end
      PH_NAME: begin
        if (digit_pos < NAME_MAX) cur_name[digit_pos] = b;
        digit_pos++;
        if (digit_pos >= hdr_nsize) begin
          if (b != 0) begin
            halt_with(ST_INVALID);
            return 1'b0;
          end
          remaining = pad_of(consumed);
          phase     = PH_NPAD;
          return skip_empty();
        end
      end
      PH_NPAD, PH_DATA, PH_DPAD: begin
        if (remaining > 0) remaining--;
        return skip_empty();
      end
      PH_TAILZ: if (b != 0) halt_with(ST_INVALID);
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic void predict_byte(in_t it);
    out_t    r;
    status_e st;
    bit      got;
    r = '0;
    if (consumed < OFF_CAP) consumed++;
    got = take_byte(it.archive_byte);
    if (it.is_last) begin
      if (consumed > {32'd0, size_limit}) st = ST_INVALID;
      else if (sticky_status != ST_OK) st = sticky_status;
      else if (phase == PH_TAILZ) st = ST_OK;
      else st = ST_INVALID;
      r.record_kind = REC_STATUS;
      r.status      = st;
      r.entry_count = (st == ST_OK) ? 6'(kept_count) : 6'd0;
      pending_records.push_back(r);
      restart_parse();
    end else if (got) begin
      r.record_kind = REC_ENTRY;
      r.entry_index = 5'(kept_count - 1);
      r.data_offset = data_base;
      r.data_size   = hdr_fsize;
      r.entry_mode  = hdr_mode;
      pending_records.push_back(r);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) predict_byte(in_data_i);
    if (rst_ni && cfg_we_i) size_limit = cfg_wdata_i;
  end

  task automatic compare_field(string nm, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, nm, e, a);
    end
  endtask

  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_records.size() == 0) begin
        errors++;
        $display("%0t: unexpected record, expected none actual %h", $time, out_data_o);
      end else begin
        e = pending_records.pop_front();
        compare_field("record_kind", e.record_kind, out_data_o.record_kind);
        compare_field("status", e.status, out_data_o.status);
        compare_field("entry_index", e.entry_index, out_data_o.entry_index);
        compare_field("data_offset", e.data_offset, out_data_o.data_offset);
        compare_field("data_size", e.data_size, out_data_o.data_size);
        compare_field("entry_mode", e.entry_mode, out_data_o.entry_mode);
        compare_field("entry_count", e.entry_count, out_data_o.entry_count);
      end
    end
  end

  initial begin
    int unsigned n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (rx_hold) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      n = no_idle ? 0 : $urandom_range(0, 3);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i) && !rx_hold);
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{archive_byte: b, is_last: last};
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
  endtask

  task automatic send_archive();
    for (int i = 0; i < arc.size(); i++) send_byte(arc[i], i == arc.size() - 1);
    arc.delete();
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [31:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic void add_hex(logic [31:0] v);
    logic [3:0] d;
    for (int i = 7; i >= 0; i--) begin
      d = v[i*4 +: 4];
      if (d < 10) arc.push_back(8'("0") + d);
      else arc.push_back(($urandom_range(0, 1) ? 8'("a") : 8'("A")) + d - 10);
    end
  endfunction

  function automatic void pad_arc();
    while (arc.size() % 4 != 0) arc.push_back(8'h00);
  endfunction

  function automatic void add_entry(string nm, logic [31:0] mode, logic [31:0] nlink,
                                    logic [31:0] fsize, logic [31:0] chk = 0,
                                    int nsz = -1);
    logic [31:0] fld [13];
    foreach (fld[i]) fld[i] = $urandom;
    fld[F_MODE]  = mode;
    fld[F_NLINK] = nlink;
    fld[F_FSIZE] = fsize;
    fld[F_NSIZE] = (nsz < 0) ? nm.len() + 1 : nsz;
    fld[F_CHECK] = chk;
    arc.push_back("0"); arc.push_back("7"); arc.push_back("0");
    arc.push_back("7"); arc.push_back("0"); arc.push_back("1");
    foreach (fld[i]) add_hex(fld[i]);
    for (int i = 0; i < nm.len(); i++) arc.push_back(nm[i]);
    arc.push_back(8'h00);
    pad_arc();
    for (int unsigned i = 0; i < fsize && i < 64; i++) arc.push_back(8'($urandom));
    pad_arc();
  endfunction

  function automatic void add_trailer();
    add_entry("TRAILER!!!", 0, 1, 0);
  endfunction

  function automatic logic [31:0] file_mode();
    return MODE_REG | 32'($urandom_range(0, 'o7777));
  endfunction

  function automatic string random_path();
    string s;
    string pool;
    int    n;
    pool = "abcxyzKLMQ0129_-./";
    s    = "";
    n    = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8) s = {s, string'(pool[$urandom_range(0, 13)])};
      else s = {s, string'(pool[$urandom_range(14, 17)])};
    end
    return s;
  endfunction

  task automatic test_well_formed();
    for (int unsigned s = 0; s < 6; s++) add_entry($sformatf("f%0d", s), file_mode(), 1, s);
    add_entry("dir_A/sub-z", MODE_DIR | 'o755, 2, 0);
    add_entry("dir_A/sub-z/Z9.t", MODE_REG, 1, 0);
    add_trailer();
    repeat (5) arc.push_back(8'h00);
    send_archive();
    add_trailer();
    send_archive();
    drain();
  endtask

  task automatic test_malformed();
    add_entry("a", file_mode(), 1, 1); arc[5] = "2"; add_trailer(); send_archive();
    add_entry("a", file_mode(), 1, 1); arc[20] = "g"; add_trailer(); send_archive();
    add_entry("a", file_mode(), 1, 1, 1); add_trailer(); send_archive();
    add_entry("a", file_mode(), 1, 1, 0, 0); add_trailer(); send_archive();
    add_entry("a", file_mode(), 1, 1, 0, 257); add_trailer(); send_archive();
    add_entry("ab", file_mode(), 1, 1, 0, 2); add_trailer(); send_archive();
    add_entry("TRAILER!!!", MODE_REG, 1, 0); send_archive();
    add_entry("TRAILER!!!", 0, 1, 4); send_archive();
    add_trailer(); arc.push_back(0); arc.push_back(8'h80); send_archive();
    add_entry("a//b", file_mode(), 1, 0); add_trailer(); send_archive();
    add_entry("./a", file_mode(), 1, 0); add_trailer(); send_archive();
    add_entry("a/..", file_mode(), 1, 0); add_trailer(); send_archive();
    add_entry("/a", file_mode(), 1, 0); add_trailer(); send_archive();
    add_entry("a/", file_mode(), 1, 0); add_trailer(); send_archive();
    add_entry(".", file_mode(), 1, 0); add_trailer(); send_archive();
    add_entry("a b", file_mode(), 1, 0); add_trailer(); send_archive();
    add_entry("", file_mode(), 1, 0); add_trailer(); send_archive();
    add_entry("lnk", 32'o120777, 1, 0); add_trailer(); send_archive();
    add_entry("f", file_mode(), 2, 3); add_trailer(); send_archive();
    add_entry("d", MODE_DIR, 2, 3); add_trailer(); send_archive();
    add_entry("f", 32'hFFFF_FFFF, 1, 0); add_trailer(); send_archive();
    add_entry("same", file_mode(), 1, 2); add_entry("same", file_mode(), 1, 0);
    add_trailer(); send_archive();
    add_entry("cut", file_mode(), 1, 9); arc = arc[0:arc.size()-6]; send_archive();
    add_entry("endsnow", file_mode(), 1, 0); send_archive();
    arc.push_back(8'hFF); send_archive();
    drain();
  endtask

  task automatic test_entry_table();
    for (int i = 0; i < 32; i++) add_entry($sformatf("e%0d", i), MODE_REG, 1, 0);
    add_trailer();
    send_archive();
    for (int i = 0; i < 33; i++) add_entry($sformatf("e%0d", i), MODE_DIR, 1, 0);
    add_trailer();
    send_archive();
    drain();
  endtask

  task automatic test_size_limit();
    int unsigned len;
    add_entry("lim", file_mode(), 1, 5); add_trailer();
    len = arc.size();
    write_limit(len);
    send_archive();
    drain();
    add_entry("lim", file_mode(), 1, 5); add_trailer();
    write_limit(len - 1);
    send_archive();
    drain();
    write_limit(32'd0);
    add_trailer(); send_archive();
    drain();
    write_limit(32'hFFFF_FFFF);
    add_entry("big", file_mode(), 1, 3); add_trailer(); send_archive();
    drain();
    write_limit(MAX_BYTES_RST);
  endtask

  task automatic random_archive();
    string nm [$];
    int    k;
    k = $urandom_range(0, 19);
    if (k == 0) begin
      repeat ($urandom_range(1, 40)) arc.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        nm.push_back((nm.size() > 0 && $urandom_range(0, 9) == 0) ?
                     nm[0] : random_path());
        if ($urandom_range(0, 3) == 0) add_entry(nm[$], MODE_DIR | 'o755, 2, 0);
        else add_entry(nm[$], file_mode(), $urandom_range(0, 5) == 0 ? 3 : 1,
                       $urandom_range(0, 9));
      end
      add_trailer();
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 6))
        arc.push_back($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'h00);
      if (k < 4) arc[$urandom_range(0, arc.size() - 1)] = 8'($urandom);
      else if (k < 6) arc = arc[0:$urandom_range(0, arc.size() - 2)];
    end
    send_archive();
  endtask

  task automatic test_random();
    bytes_sent = 0;
    while (bytes_sent < 850) begin
      no_idle = ($urandom_range(0, 7) == 0);
      random_archive();
    end
    no_idle = 1'b0;
    drain();
  endtask

  task automatic test_backpressure();
    rx_hold = 1'b1;
    for (int i = 0; i < 6; i++) add_entry($sformatf("bp%0d", i), file_mode(), 1, 0);
    add_trailer();
    send_archive();
    drain();
  endtask

  initial begin
    #50ms;
    $display("cpio_newc_archive_validator verification failed");
    $finish;
  end

  initial begin
    errors      = 0;
    no_idle     = 1'b0;
    rx_hold     = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    size_limit  = MAX_BYTES_RST;
    restart_parse();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_well_formed();
    test_malformed();
    test_entry_table();
    test_size_limit();
    test_backpressure();
    test_random();
    if (errors == 0) begin
      $display("cpio_newc_archive_validator verification clean");
    end else begin
      $display("cpio_newc_archive_validator verification failed");
    end
    $finish;
  end

endmodule
